// File: rtl/core/nnls_pkg.sv
// nnls_pkg: shared types and constants of the nth non-blank line selector.
// No dependencies; imported by nnls_scan, nnls_reply and the top level.
package nnls_pkg;

   // Request operation codes (req_tuser).
   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_END  = 2'd1,
      OP_READ = 2'd2
   } op_type;

   // Response kind (rsp_tuser).
   typedef enum logic {
      KIND_SUMMARY = 1'b0,
      KIND_READ    = 1'b1
   } kind_type;

   localparam logic [7:0]  BYTE_NL   = 8'h0A;
   localparam logic [7:0]  BYTE_TAB  = 8'h09;
   localparam logic [7:0]  BYTE_CR   = 8'h0D;
   localparam logic [7:0]  BYTE_SP   = 8'h20;
   localparam logic [7:0]  MARK_B0   = 8'hEF;
   localparam logic [7:0]  MARK_B1   = 8'hBB;
   localparam logic [7:0]  MARK_B2   = 8'hBF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   // Response fields computed at request time, handed to the reply stage.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] total;
      logic        found;
      logic [8:0]  length;
      logic        in_range;  // read address below captured length
   } reply_type;

endpackage

// File: rtl/core/nnls_ram.sv
// nnls_ram: generic single-port RAM, registered read.
// No dependencies.
module nnls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/nnls_scan.sv
// nnls_scan: line scanner; per-request state update, store write/read issue.
// Depends on nnls_pkg.
module nnls_scan #(
   parameter int LINE_CAPACITY   = 512,
   parameter int OUTPUT_CAPACITY = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_accept,
   input  logic [1:0]                         operation,
   input  logic [7:0]                         data_byte,
   input  logic [8:0]                         read_address,
   input  logic [15:0]                        target_line,
   output logic                               ram_we,
   output logic                               ram_re,
   output logic [$clog2(OUTPUT_CAPACITY)-1:0] ram_addr,
   output logic [7:0]                         ram_wdata,
   output logic                               reply_valid,
   output nnls_pkg::reply_type                reply
);
   import nnls_pkg::*;

   localparam int LenW  = $clog2(LINE_CAPACITY);
   localparam int AddrW = $clog2(OUTPUT_CAPACITY);
   localparam int WideW = ((LenW > AddrW) ? LenW : AddrW) + 1;
   localparam int CmpW  = (AddrW > 9) ? AddrW : 9;

   logic [LenW-1:0]  line_length_ff, line_length_in;
   logic [15:0]      line_count_ff, line_count_in;
   logic             captured_flag_ff, captured_flag_in;
   logic             nonblank_any_ff, nonblank_any_in;
   logic             nonblank_after_mark_ff, nonblank_after_mark_in;
   logic             mark_prefix_seen_ff, mark_prefix_seen_in;
   logic             capture_offset_ff, capture_offset_in;  // set means offset 3
   logic [AddrW-1:0] capture_length_ff, capture_length_in;

   op_type           op;
   logic             cnt_zero, hit_target, is_blank, clipped;
   logic             strip, nonblank, base_cap, mark_new, end_cap;
   logic [LenW-1:0]  text_len, wr_pos;
   logic [AddrW-1:0] close_len, base_len, end_len;
   logic [15:0]      count_inc, end_count;

   always_comb begin
      op         = op_type'(operation);
      cnt_zero   = (line_count_ff == '0);
      hit_target = (line_count_ff == target_line);
      is_blank   = data_byte inside {BYTE_SP, BYTE_TAB, BYTE_CR};
      clipped    = (line_length_ff == LenW'(LINE_CAPACITY - 1));

      // line close terms
      strip     = cnt_zero && (line_length_ff >= LenW'(3)) && mark_prefix_seen_ff;
      text_len  = strip ? line_length_ff - LenW'(3) : line_length_ff;
      nonblank  = strip ? nonblank_after_mark_ff : nonblank_any_ff;
      close_len = (WideW'(text_len) < WideW'(OUTPUT_CAPACITY - 1)) ?
                  AddrW'(text_len) : AddrW'(OUTPUT_CAPACITY - 1);
      count_inc = (line_count_ff != COUNT_MAX) ? line_count_ff + 16'd1 : line_count_ff;

      // a new stream drops the previous capture
      base_cap = cnt_zero ? 1'b0 : captured_flag_ff;
      base_len = cnt_zero ? '0 : capture_length_ff;

      wr_pos   = (line_length_ff >= LenW'(3) && capture_offset_ff) ?
                 line_length_ff - LenW'(3) : line_length_ff;
      mark_new = mark_prefix_seen_ff;
      if (line_length_ff == LenW'(0)) begin
         mark_new = (data_byte == MARK_B0);
      end else if (line_length_ff == LenW'(1)) begin
         mark_new = mark_prefix_seen_ff && (data_byte == MARK_B1);
      end else if (line_length_ff == LenW'(2)) begin
         mark_new = mark_prefix_seen_ff && (data_byte == MARK_B2);
      end

      end_cap   = captured_flag_ff;
      end_len   = capture_length_ff;
      end_count = line_count_ff;

      line_length_in         = line_length_ff;
      line_count_in          = line_count_ff;
      captured_flag_in       = captured_flag_ff;
      nonblank_any_in        = nonblank_any_ff;
      nonblank_after_mark_in = nonblank_after_mark_ff;
      mark_prefix_seen_in    = mark_prefix_seen_ff;
      capture_offset_in      = capture_offset_ff;
      capture_length_in      = capture_length_ff;

      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_addr    = AddrW'(wr_pos);
      ram_wdata   = data_byte;
      reply_valid = 1'b0;
      reply       = '{kind: KIND_SUMMARY, total: line_count_ff, found: captured_flag_ff,
                      length: 9'(capture_length_ff), in_range: 1'b0};

      if (req_accept) begin
         case (op)
            OP_BYTE: begin
               captured_flag_in  = base_cap;
               capture_length_in = base_len;
               if (data_byte == BYTE_NL) begin
                  if (nonblank) begin
                     if (hit_target && !base_cap) begin
                        captured_flag_in  = 1'b1;
                        capture_length_in = close_len;
                     end
                     line_count_in = count_inc;
                  end
                  line_length_in         = '0;
                  nonblank_any_in        = 1'b0;
                  nonblank_after_mark_in = 1'b0;
                  mark_prefix_seen_in    = 1'b0;
                  capture_offset_in      = 1'b0;
               end else if (!clipped) begin
                  if (!is_blank) begin
                     nonblank_any_in = 1'b1;
                     if (line_length_ff >= LenW'(3)) begin
                        nonblank_after_mark_in = 1'b1;
                     end
                  end
                  mark_prefix_seen_in = mark_new;
                  ram_we = hit_target && !base_cap &&
                           (WideW'(wr_pos) < WideW'(OUTPUT_CAPACITY - 1));
                  if (line_length_ff == LenW'(2) && cnt_zero && mark_new) begin
                     capture_offset_in = 1'b1;
                  end
                  line_length_in = line_length_ff + LenW'(1);
               end
            end
            OP_END: begin
               if (line_length_ff != '0 && nonblank) begin
                  if (hit_target && !captured_flag_ff) begin
                     end_cap = 1'b1;
                     end_len = close_len;
                  end
                  end_count = count_inc;
               end
               if (end_count == '0) begin
                  end_cap = 1'b0;
                  end_len = '0;
               end
               captured_flag_in       = end_cap;
               capture_length_in      = end_len;
               line_count_in          = '0;
               line_length_in         = '0;
               nonblank_any_in        = 1'b0;
               nonblank_after_mark_in = 1'b0;
               mark_prefix_seen_in    = 1'b0;
               capture_offset_in      = 1'b0;
               reply_valid            = 1'b1;
               reply = '{kind: KIND_SUMMARY, total: end_count, found: end_cap,
                         length: 9'(end_len), in_range: 1'b0};
            end
            OP_READ: begin
               ram_re      = 1'b1;
               ram_addr    = AddrW'(read_address);
               reply_valid = 1'b1;
               reply.kind  = KIND_READ;
               reply.in_range = CmpW'(read_address) < CmpW'(capture_length_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff         <= '0;
         line_count_ff          <= '0;
         captured_flag_ff       <= 1'b0;
         nonblank_any_ff        <= 1'b0;
         nonblank_after_mark_ff <= 1'b0;
         mark_prefix_seen_ff    <= 1'b0;
         capture_offset_ff      <= 1'b0;
         capture_length_ff      <= '0;
      end else begin
         line_length_ff         <= line_length_in;
         line_count_ff          <= line_count_in;
         captured_flag_ff       <= captured_flag_in;
         nonblank_any_ff        <= nonblank_any_in;
         nonblank_after_mark_ff <= nonblank_after_mark_in;
         mark_prefix_seen_ff    <= mark_prefix_seen_in;
         capture_offset_ff      <= capture_offset_in;
         capture_length_ff      <= capture_length_in;
      end
   end

   a_end_clears_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && op == OP_END |=> line_count_ff == '0)
      else $error("line count not cleared after end of stream");

   a_write_only_candidate: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> hit_target && (cnt_zero || !captured_flag_ff))
      else $error("store written outside candidate line");

   a_length_needs_flag: assert property (@(posedge clock) disable iff (reset)
      !captured_flag_ff |-> capture_length_ff == '0)
      else $error("capture length set without capture");

endmodule

// File: rtl/core/nnls_reply.sv
// nnls_reply: response pipeline; waits on store read data, then output register.
// Depends on nnls_pkg.
module nnls_reply (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_accept,
   input  logic                                  reply_valid,
   input  nnls_pkg::reply_type                   reply,
   input  logic [7:0]                            ram_rdata,
   output logic                                  req_tready,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tuser,
   output logic [nnls_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import nnls_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   reply_type s1_ff;
   logic      out_valid_ff, out_valid_in;
   reply_type out_ff;
   logic [7:0] out_byte_ff, out_byte_in;
   logic      s1_adv;

   // s1 holds a request while its store read completes
   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || !out_valid_ff || rsp_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (reply_valid) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      out_byte_in = (s1_ff.kind == KIND_READ && s1_ff.in_range) ? ram_rdata : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reply_valid) begin
         s1_ff <= reply;
      end
      if (s1_adv) begin
         out_ff      <= s1_ff;
         out_byte_ff <= out_byte_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {6'd0, out_byte_ff, out_ff.length, out_ff.found, out_ff.total};

   a_s1_moves_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept && s1_valid_ff |-> s1_adv)
      else $error("pending response overwritten");

   a_s1_holds_when_full: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_tready |=> s1_valid_ff && $stable(s1_ff))
      else $error("stalled response lost");

   a_summary_byte_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind == KIND_SUMMARY |-> out_byte_ff == 8'd0)
      else $error("summary carries a read byte");

endmodule

// File: rtl/core/nth_nonblank_line_selector.sv
// nth_nonblank_line_selector: top level; config register and unit hookup.
// Depends on nnls_pkg, nnls_scan, nnls_ram, nnls_reply.
// Throughput: one request per cycle, text bytes, end-of-stream and reads alike,
//   while rsp_* keeps up; req_tready drops when the response path backs up.
// Response path: middle stage for the store's registered read, then output register.
// Reset: synchronous, active high; clears line state, count, capture flag and
//   length, and the target register. The capture store is not cleared.
module nth_nonblank_line_selector #(
   parameter int LINE_CAPACITY   = 512,  // line buffer; lines clip at this minus one
   parameter int OUTPUT_CAPACITY = 512   // capture store depth
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [nnls_pkg::REQ_DATA_W-1:0]    req_tdata,  // data_byte[7:0], read_address[16:8]
   input  logic [1:0]                         req_tuser,  // operation[1:0]
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // line_total[15:0], line_found[16], captured_length[25:17], read_byte[33:26]
   output logic [nnls_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,  // reply_kind[0]
   // target line register
   input  logic                               csr_wr_en,
   input  logic [15:0]                        csr_wr_data
);
   import nnls_pkg::*;

   localparam int AddrW = $clog2(OUTPUT_CAPACITY);

   logic [15:0]      target_line_ff;
   logic             req_accept;
   logic             ram_we, ram_re;
   logic [AddrW-1:0] ram_addr;
   logic [7:0]       ram_wdata, ram_rdata;
   logic             reply_valid;
   reply_type        reply;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_line_ff <= '0;
      end else if (csr_wr_en) begin
         target_line_ff <= csr_wr_data;
      end
   end

   assign req_accept = req_tvalid && req_tready;

   // Scanner: updates the line state in the accept cycle and issues the
   // store access; bytes of the target line go straight into the store.
   nnls_scan #(
      .LINE_CAPACITY  (LINE_CAPACITY),
      .OUTPUT_CAPACITY(OUTPUT_CAPACITY)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .operation   (req_tuser),
      .data_byte   (req_tdata[7:0]),
      .read_address(req_tdata[16:8]),
      .target_line (target_line_ff),
      .ram_we      (ram_we),
      .ram_re      (ram_re),
      .ram_addr    (ram_addr),
      .ram_wdata   (ram_wdata),
      .reply_valid (reply_valid),
      .reply       (reply)
   );

   // Capture store. A write and a read never share a cycle, and a read issued
   // after a write already sees the new byte.
   nnls_ram #(
      .WIDTH(8),
      .DEPTH(OUTPUT_CAPACITY)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .re   (ram_re),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // Response stage plus output register; keeps accepting while the
   // output register holds a response as long as the middle stage is free.
   nnls_reply u_reply (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .reply_valid(reply_valid),
      .reply      (reply),
      .ram_rdata  (ram_rdata),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: bench/nth_nonblank_line_selector_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for nth_nonblank_line_selector: text streams, end-of-stream
// summaries and capture reads, checked against a line-selection predictor.
// Depends on nnls_pkg and the nth_nonblank_line_selector RTL only.
module nth_nonblank_line_selector_tb;
   import nnls_pkg::*;

   localparam int LINE_CAP       = 512;
   localparam int OUT_CAP        = 512;
   localparam int WATCHDOG_LIMIT = 2000;   // idle cycles
   localparam int SETTLE_CYCLES  = 4;      // settle time after the queues drain
   localparam int LONG_HOLD      = 160;    // receiver back-pressure stretch
   localparam int HOLD_BACKLOG   = 16;     // pending requests needed to start a hold
   localparam logic [1:0] OP_SPARE = 2'd3; // unused opcode, must be ignored

   // One request as queued for the driver.
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
      logic [8:0] addr;
   } text_request_type;

   // One response as the selector should return it.
   typedef struct {
      kind_type    kind;
      logic [15:0] total;
      logic        found;
      logic [8:0]  length;
      logic [7:0]  rd_byte;
   } line_reply_type;

   // DUT ports; every input known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // data_byte[7:0], read_address[16:8]
   logic [1:0]  req_tuser = OP_BYTE;       // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // line_total[15:0], line_found[16], captured_length[25:17], read_byte[33:26]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic        rsp_tuser;                 // reply_kind[0]
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   nth_nonblank_line_selector #(
      .LINE_CAPACITY  (LINE_CAP),
      .OUTPUT_CAPACITY(OUT_CAP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Line-selection predictor: own copy of the selector state, updated once per
   // accepted request.
   // ---------------------------------------------------------------------------
   logic [7:0]  cap_mem [0:OUT_CAP-1];
   logic [8:0]  ln_len       = '0;   // bytes kept in the current line (clips at 511)
   logic [15:0] nb_count     = '0;   // non-blank lines so far, saturating
   logic        cap_found    = 1'b0;
   logic        nb_any       = 1'b0; // non-blank byte anywhere in the line
   logic        nb_after_bom = 1'b0; // non-blank byte past the first three
   logic        bom_seen     = 1'b0; // line so far matches EF BB BF
   logic [1:0]  cap_ofs      = '0;   // 3 once a leading mark is to be stripped
   logic [8:0]  cap_len      = '0;
   logic [15:0] tgt_line     = '0;

   line_reply_type   replies_due[$];       // expected responses, oldest first
   text_request_type requests_pending[$];  // requests waiting for the driver

   function automatic void clear_line_state();
      ln_len       = '0;
      nb_any       = 1'b0;
      nb_after_bom = 1'b0;
      bom_seen     = 1'b0;
      cap_ofs      = '0;
   endfunction

   // Newline or end of stream: count the line if it holds text, commit capture.
   function automatic void close_text_line();
      logic       strip;
      logic [8:0] txt_len;
      logic       nb;
      strip   = (nb_count == 0) && (ln_len >= 9'd3) && bom_seen;
      txt_len = strip ? ln_len - 9'd3 : ln_len;
      nb      = strip ? nb_after_bom : nb_any;
      if (nb) begin
         if (nb_count == tgt_line && !cap_found) begin
            cap_len   = (txt_len < 9'(OUT_CAP - 1)) ? txt_len : 9'(OUT_CAP - 1);
            cap_found = 1'b1;
         end
         if (nb_count != COUNT_MAX)
            nb_count = nb_count + 16'd1;
      end
      clear_line_state();
   endfunction

   function automatic void take_text_byte(input logic [7:0] b);
      logic [8:0] p;
      logic [8:0] wa;
      logic       nb;
      p = ln_len;
      // first byte of a fresh stream drops the old capture
      if (nb_count == 0) begin
         cap_found = 1'b0;
         cap_len   = '0;
      end
      if (b == BYTE_NL) begin
         close_text_line();
         return;
      end
      if (p == 9'(LINE_CAP - 1))
         return;                       // clipped tail of a long line
      nb = !(b == BYTE_SP || b == BYTE_TAB || b == BYTE_CR);
      if (nb) begin
         nb_any = 1'b1;
         if (p >= 9'd3)
            nb_after_bom = 1'b1;
      end
      if (p == 9'd0)
         bom_seen = (b == MARK_B0);
      else if (p == 9'd1)
         bom_seen = bom_seen && (b == MARK_B1);
      else if (p == 9'd2)
         bom_seen = bom_seen && (b == MARK_B2);
      // candidate write; becomes the capture only if the line ends non-blank
      if (nb_count == tgt_line && !cap_found) begin
         wa = (p >= 9'd3) ? p - 9'(cap_ofs) : p;
         if (wa < 9'(OUT_CAP - 1))
            cap_mem[wa] = b;
      end
      if (p == 9'd2 && nb_count == 0 && bom_seen)
         cap_ofs = 2'd3;
      ln_len = p + 9'd1;
   endfunction

   function automatic void predict_request(input text_request_type rq);
      line_reply_type r;
      case (rq.op)
         OP_BYTE: take_text_byte(rq.data_byte);
         OP_END: begin
            if (ln_len != 0)
               close_text_line();
            if (nb_count == 0) begin
               cap_found = 1'b0;
               cap_len   = '0;
            end
            r.kind    = KIND_SUMMARY;
            r.total   = nb_count;
            r.found   = cap_found;
            r.length  = cap_len;
            r.rd_byte = '0;
            replies_due.push_back(r);
            nb_count = '0;
            clear_line_state();
         end
         OP_READ: begin
            r.kind    = KIND_READ;
            r.total   = nb_count;
            r.found   = cap_found;
            r.length  = cap_len;
            r.rd_byte = (rq.addr < cap_len) ? cap_mem[rq.addr] : 8'h00;
            replies_due.push_back(r);
         end
         default: ;                    // spare opcode: no effect
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Shared bench state
   // ---------------------------------------------------------------------------
   int  req_offered  = 0;   // requests put on the bus (driver)
   int  req_accepts  = 0;   // requests taken by the DUT (monitor)
   int  rsp_seen     = 0;   // responses taken from the DUT
   int  mismatches   = 0;
   int  queued_reqs  = 0;
   int  queued_reps  = 0;   // queued requests that produce a response
   int  targets_set  = 0;
   bit  burst_mode   = 1'b0; // no random gaps on either side while set; long holds still apply
   int  send_gap     = 0;
   int  hold_left    = 0;
   int  long_holds   = 0;
   int  hold_mark    = 14;  // response count that starts the next long hold
   int  idle_cycles  = 0;
   text_request_type cur_req;

   task automatic report_mismatch(input string msg);
      if (mismatches < 40)
         $display("mismatch @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("response %0d %s: got 0x%0h, want 0x%0h",
                                   rsp_seen, name, got, want));
   endtask

   // Mostly back-to-back, sometimes short gaps, rarely long ones.
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: presents queued requests at the falling edge and holds
   // each one until the rising edge that takes it.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && req_accepts != req_offered) begin
         // still waiting for tready: keep the request on the bus
      end else if (send_gap > 0) begin
         send_gap--;
         req_tvalid <= 1'b0;
      end else if (requests_pending.size() > 0) begin
         cur_req = requests_pending.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= {7'd0, cur_req.addr, cur_req.data_byte};
         req_tuser  <= cur_req.op;
         req_offered++;
         send_gap = burst_mode ? 0 : draw_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Response receiver: random stalls, plus up to two long holds that start
   // only with a backlog queued, so the selector backs up and drops req_tready.
   always @(negedge clock) begin
      int g;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_left == 0 && long_holds < 2 && rsp_seen >= hold_mark &&
             requests_pending.size() >= HOLD_BACKLOG) begin
            hold_left = LONG_HOLD;
            long_holds++;
            hold_mark = rsp_seen + 20;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            g = burst_mode ? 0 : draw_gap();
            if (g == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               hold_left = g - 1;
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   // Request acceptance feeds the predictor; response acceptance is checked.
   always @(posedge clock) begin
      line_reply_type exp_r;
      if (!reset && req_tvalid && req_tready) begin
         predict_request(cur_req);
         req_accepts++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (replies_due.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with none expected", rsp_seen));
         end else begin
            exp_r = replies_due.pop_front();
            check_field("reply_kind", int'(rsp_tuser), int'(exp_r.kind));
            check_field("line_total", int'(rsp_tdata[15:0]), int'(exp_r.total));
            check_field("line_found", int'(rsp_tdata[16]), int'(exp_r.found));
            check_field("captured_length", int'(rsp_tdata[25:17]), int'(exp_r.length));
            check_field("read_byte", int'(rsp_tdata[33:26]), int'(exp_r.rd_byte));
         end
         rsp_seen++;
      end
   end

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("no handshake for %0d cycles, %0d responses outstanding",
                  WATCHDOG_LIMIT, replies_due.size());
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic push_req(input logic [1:0] op, input logic [7:0] b, input logic [8:0] a);
      text_request_type rq;
      rq.op        = op;
      rq.data_byte = b;
      rq.addr      = a;
      requests_pending.push_back(rq);
      queued_reqs++;
      if (op == OP_END || op == OP_READ)
         queued_reps++;
   endtask

   task automatic push_byte(input logic [7:0] b);
      push_req(OP_BYTE, b, '0);
   endtask

   task automatic push_read(input logic [8:0] a);
      push_req(OP_READ, '0, a);
   endtask

   // Mostly printable text with the odd space, tab or CR.
   function automatic logic [7:0] draw_text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)  return BYTE_SP;
      if (r < 8)  return BYTE_TAB;
      if (r < 10) return BYTE_CR;
      return 8'($urandom_range(8'h21, 8'h7E));
   endfunction

   function automatic logic [8:0] draw_addr();
      if ($urandom_range(0, 99) < 80)
         return 9'($urandom_range(0, 31));
      return 9'($urandom_range(0, 511));
   endfunction

   task automatic push_body(input int n, input bit raw);
      int i;
      for (i = 0; i < n; i++)
         push_byte(raw ? 8'($urandom_range(0, 255)) : draw_text_byte());
   endtask

   task automatic push_blank(input int n);
      int i;
      int r;
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 2);
         push_byte(r == 0 ? BYTE_SP : (r == 1 ? BYTE_TAB : BYTE_CR));
      end
   endtask

   // One random line body (no newline).
   task automatic push_random_line();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         // empty line
      end else if (r < 25) begin
         push_blank($urandom_range(1, 6));
      end else if (r < 58) begin
         push_body($urandom_range(1, 24), 1'b0);
      end else if (r < 72) begin
         // leading byte-order mark, then text, whitespace or nothing
         push_byte(MARK_B0);
         push_byte(MARK_B1);
         push_byte(MARK_B2);
         case ($urandom_range(0, 2))
            0: push_body($urandom_range(1, 16), 1'b0);
            1: push_blank($urandom_range(1, 4));
            default: ;
         endcase
      end else if (r < 82) begin
         // broken mark prefix
         push_byte(MARK_B0);
         if ($urandom_range(0, 1)) begin
            push_byte(MARK_B1);
            push_byte(8'($urandom_range(0, 8'hBE)));
         end
         push_body($urandom_range(0, 8), 1'b0);
      end else if (r < 92) begin
         push_body($urandom_range(1, 20), 1'b1);   // any byte value, NUL included
      end else begin
         push_body($urandom_range(30, 90), 1'b0);
      end
   endtask

   task automatic push_random_stream();
      int n_lines;
      int i;
      n_lines = $urandom_range(0, 7);
      for (i = 0; i < n_lines; i++) begin
         push_random_line();
         // last line is sometimes left open for end of stream to close
         if (i != n_lines - 1 || $urandom_range(0, 99) < 70)
            push_byte(BYTE_NL);
         if ($urandom_range(0, 99) < 15)
            push_read(draw_addr());
         if ($urandom_range(0, 99) < 3)
            push_req(OP_SPARE, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      end
      push_req(OP_END, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      n_lines = $urandom_range(1, 5);
      for (i = 0; i < n_lines; i++)
         push_read(draw_addr());
   endtask

   // Let everything queued drain, then the pipeline empty out.
   task automatic wait_drained();
      while (requests_pending.size() != 0 || req_accepts != req_offered ||
             replies_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Target line changes only with the selector idle at a stream boundary.
   task automatic set_target(input logic [15:0] v);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      tgt_line = v;
      targets_set++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [15:0] draw_target();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return 16'd0;
      if (r < 70) return 16'($urandom_range(1, 3));
      if (r < 90) return 16'($urandom_range(4, 8));
      if (r < 95) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      int i;
      int rand_start;
      int reps_start;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, target 0 from reset: mark-stripped first line, NUL counts.
      push_byte(MARK_B0);
      push_byte(MARK_B1);
      push_byte(MARK_B2);
      push_byte("A");
      push_byte(BYTE_NL);
      push_byte(8'h00);
      push_byte(BYTE_NL);
      push_req(OP_END, '0, '0);
      push_read(9'd0);

      // Target 1: mark followed only by whitespace is blank; a mark on a later
      // line is plain text; end of stream closes an open line.
      set_target(16'd1);
      push_byte(MARK_B0);
      push_byte(MARK_B1);
      push_byte(MARK_B2);
      push_byte(BYTE_SP);
      push_byte(BYTE_TAB);
      push_byte(BYTE_CR);
      push_byte(BYTE_NL);
      push_byte("a");
      push_byte(BYTE_NL);
      push_byte(MARK_B0);
      push_byte(MARK_B1);
      push_byte(MARK_B2);
      push_byte("b");
      push_byte(BYTE_NL);
      push_byte(8'hFF);
      push_req(OP_END, 8'hFF, 9'h1FF);
      push_read(9'd3);
      push_req(OP_SPARE, 8'hFF, 9'h1FF);
      // empty stream drops the capture
      push_req(OP_END, '0, '0);
      push_read(9'd0);

      // Clipping: a long first line keeps 511 bytes; the last kept byte and
      // the first position past the capture are read back.
      set_target(16'd0);
      push_body(515, 1'b0);
      push_byte(BYTE_NL);
      push_req(OP_END, '0, '0);
      push_read(9'd0);
      push_read(9'd510);
      push_read(9'd511);

      // Random streams, a new target and idling style for each batch.
      rand_start = queued_reqs;
      reps_start = queued_reps;
      while (queued_reqs - rand_start < 180 || queued_reps - reps_start < 24) begin
         set_target(draw_target());
         burst_mode = ($urandom_range(0, 99) < 25);
         for (i = $urandom_range(1, 3); i > 0; i--)
            push_random_stream();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (replies_due.size() != 0)
         report_mismatch($sformatf("%0d expected responses never arrived",
                                   replies_due.size()));
      $display("covered %0d requests and %0d responses over %0d target settings,",
               req_accepts, rsp_seen, targets_set);
      $display("with mark stripping, blank lines, line clipping and back-pressure");
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
